// ----- rtl/sss_pkg.sv -----
// Shared types and codes for the sorted set store.
// Used by sss_front, sss_fifo, sss_back and sorted_set_store_unit; no dependencies.
`default_nettype none

package sss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int QUEUE_DEPTH  = 2;

    // request mode codes
    localparam logic [3:0] MODE_INSERT    = 4'd0;
    localparam logic [3:0] MODE_REMOVE    = 4'd1;
    localparam logic [3:0] MODE_EXISTS    = 4'd2;
    localparam logic [3:0] MODE_MIN       = 4'd3;
    localparam logic [3:0] MODE_MAX       = 4'd4;
    localparam logic [3:0] MODE_TAKE_MIN  = 4'd5;
    localparam logic [3:0] MODE_TAKE_MAX  = 4'd6;
    localparam logic [3:0] MODE_PRED      = 4'd7;
    localparam logic [3:0] MODE_SUCC      = 4'd8;
    localparam logic [3:0] MODE_TAKE_PRED = 4'd9;
    localparam logic [3:0] MODE_TAKE_SUCC = 4'd10;
    localparam logic [3:0] MODE_CLEAR     = 4'd11;

    // response status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_ABSENT = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_EXISTS,
        OP_MIN,
        OP_MAX,
        OP_PRED,
        OP_SUCC,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [6:0]  count;
    } out_beat_t;

    // decoded command held in the queue
    typedef struct packed {
        op_t         op;
        logic        take;
        logic [31:0] key;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sss_front.sv -----
// Request front end: accepts beats and decodes the mode into a command.
// Depends on sss_pkg.
`default_nettype none

module sss_front (
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire sss_pkg::in_beat_t req,
    input  wire logic            q_full,
    output logic                 push,
    output sss_pkg::cmd_t        push_cmd
);
    import sss_pkg::*;

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

    always_comb
    begin
        push_cmd.key  = req.key;
        push_cmd.take = 1'b0;
        push_cmd.op   = OP_NOP;
        case (req.mode)
            MODE_INSERT:    push_cmd.op = OP_INSERT;
            MODE_REMOVE:    push_cmd.op = OP_REMOVE;
            MODE_EXISTS:    push_cmd.op = OP_EXISTS;
            MODE_MIN:       push_cmd.op = OP_MIN;
            MODE_MAX:       push_cmd.op = OP_MAX;
            MODE_PRED:      push_cmd.op = OP_PRED;
            MODE_SUCC:      push_cmd.op = OP_SUCC;
            MODE_CLEAR:     push_cmd.op = OP_CLEAR;
            MODE_TAKE_MIN:
            begin
                push_cmd.op   = OP_MIN;
                push_cmd.take = 1'b1;
            end
            MODE_TAKE_MAX:
            begin
                push_cmd.op   = OP_MAX;
                push_cmd.take = 1'b1;
            end
            MODE_TAKE_PRED:
            begin
                push_cmd.op   = OP_PRED;
                push_cmd.take = 1'b1;
            end
            MODE_TAKE_SUCC:
            begin
                push_cmd.op   = OP_SUCC;
                push_cmd.take = 1'b1;
            end
            default:        push_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sss_fifo.sv -----
// Short command queue between front end and back end.
// Depends on sss_pkg.
`default_nettype none

module sss_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sss_pkg::cmd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output sss_pkg::cmd_t      rdata
);
    import sss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sss_back.sv -----
// Back end: sorted row of key cells with per-cell compare and shift,
// a two-state sequencer and the response register. Depends on sss_pkg.
`default_nettype none

module sss_back #(
    parameter int CAPACITY = sss_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sss_pkg::KEY_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire sss_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sss_pkg::out_beat_t rsp
);
    import sss_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_LOAD,
        S_APPLY
    } state_t;

    state_t                state_reg;
    logic [KEY_BITS-1:0]   entry_reg  [CAPACITY];
    logic [KEY_BITS-1:0]   entry_next [CAPACITY];
    logic [KEY_BITS-1:0]   entry_up   [CAPACITY];
    logic [KEY_BITS-1:0]   entry_dn   [CAPACITY];
    logic [CNT_W-1:0]      used_reg, used_next;
    cmd_t                  cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [CAPACITY-1:0]   lt_reg, eq_reg, gt_reg;
    logic [CAPACITY-1:0]   lt_c, eq_c, gt_c;
    logic [CAPACITY-1:0]   cell_vld;
    logic [CAPACITY:0]     vld_pad, lt_pad;
    logic [CAPACITY-1:0]   lt_dn, gt_dn;
    logic [CAPACITY-1:0]   tgt, drop;
    logic                  rsp_valid_reg;
    out_beat_t             rsp_reg;
    logic [63:0]           head_wide;
    logic [KEY_BITS-1:0]   head_key;
    logic [KEY_BITS-1:0]   sel_val;
    logic [63:0]           sel_wide;
    logic                  load_go, apply_go;
    logic                  empty, full, any_eq, found;
    logic                  do_ins, do_drop, do_clear, give_value;
    logic [2:0]            status;

    assign head_wide = 64'(q_head.key);
    assign head_key  = head_wide[KEY_BITS-1:0];

    assign load_go  = (state_reg == S_LOAD) && q_valid;
    assign q_pop    = load_go;
    assign apply_go = (state_reg == S_APPLY) && (!rsp_valid_reg || !rsp_stall);

    // per-cell compare against the queue head and neighbor wiring
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_vld[i] = (used_reg > CNT_W'(i));
        assign lt_c[i]     = cell_vld[i] && (entry_reg[i] <  head_key);
        assign eq_c[i]     = cell_vld[i] && (entry_reg[i] == head_key);
        assign gt_c[i]     = cell_vld[i] && (entry_reg[i] >  head_key);
        if (i == CAPACITY - 1)
        begin : g_last
            assign entry_up[i] = entry_reg[i];
        end
        else
        begin : g_mid
            assign entry_up[i] = entry_reg[i+1];
        end
        if (i == 0)
        begin : g_first
            assign entry_dn[i] = key_reg;
        end
        else
        begin : g_rest
            assign entry_dn[i] = entry_reg[i-1];
        end
    end

    assign vld_pad = {1'b0, cell_vld};
    assign lt_pad  = {1'b0, lt_reg};
    assign lt_dn   = {lt_reg[CAPACITY-2:0], 1'b1};
    assign gt_dn   = {gt_reg[CAPACITY-2:0], 1'b0};

    assign empty  = (used_reg == '0);
    assign full   = (used_reg == CNT_W'(CAPACITY));
    assign any_eq = |eq_reg;

    // target cell (one-hot) and cells that pull from their upper neighbor
    always_comb
    begin
        tgt  = '0;
        drop = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (cmd_reg.op)
                OP_REMOVE:
                begin
                    tgt[i]  = eq_reg[i];
                    drop[i] = !lt_reg[i];
                end
                OP_MIN:
                begin
                    tgt[i]  = (i == 0);
                    drop[i] = 1'b1;
                end
                OP_MAX:
                begin
                    tgt[i]  = vld_pad[i] && !vld_pad[i+1];
                end
                OP_PRED:
                begin
                    tgt[i]  = lt_pad[i] && !lt_pad[i+1];
                    drop[i] = !lt_pad[i+1];
                end
                OP_SUCC:
                begin
                    tgt[i]  = gt_reg[i] && !gt_dn[i];
                    drop[i] = gt_reg[i];
                end
                default:
                begin
                    tgt[i]  = 1'b0;
                    drop[i] = 1'b0;
                end
            endcase
        end
    end

    assign found = |tgt;

    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_val = sel_val | (tgt[i] ? entry_reg[i] : '0);
        end
    end

    assign sel_wide = 64'(sel_val);

    always_comb
    begin
        status     = ST_OK;
        do_ins     = 1'b0;
        do_drop    = 1'b0;
        do_clear   = 1'b0;
        give_value = 1'b0;
        case (cmd_reg.op)
            OP_INSERT:
            begin
                if (any_eq)
                begin
                    status = ST_DUP;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (any_eq)
                begin
                    do_drop = 1'b1;
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
            OP_EXISTS:
            begin
                if (!any_eq)
                begin
                    status = ST_ABSENT;
                end
            end
            OP_MIN, OP_MAX, OP_PRED, OP_SUCC:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (!found)
                begin
                    status = ST_ABSENT;
                end
                else
                begin
                    give_value = 1'b1;
                    do_drop    = cmd_reg.take;
                end
            end
            OP_CLEAR:
            begin
                do_clear = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (do_clear)
        begin
            used_next = '0;
        end
        else if (do_ins)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (do_drop)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    // cell update: insert opens a slot at the first cell not below the key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (do_ins && !lt_reg[i])
            begin
                entry_next[i] = lt_dn[i] ? key_reg : entry_dn[i];
            end
            else if (do_drop && drop[i])
            begin
                entry_next[i] = entry_up[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            cmd_reg <= q_head;
            key_reg <= head_key;
            lt_reg  <= lt_c;
            eq_reg  <= eq_c;
            gt_reg  <= gt_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // a new response in the same cycle takes the slot instead
            if (rsp_valid_reg && !rsp_stall && !apply_go)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (load_go)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (apply_go)
                    begin
                        state_reg      <= S_LOAD;
                        used_reg       <= used_next;
                        rsp_valid_reg  <= 1'b1;
                        rsp_reg.status <= status;
                        rsp_reg.value  <= give_value ? sel_wide[31:0] : 32'd0;
                        rsp_reg.count  <= 7'(used_next);
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/sorted_set_store_unit.sv -----
// Top level of the sorted set store: front end, command queue, back end.
// Depends on sss_pkg, sss_front, sss_fifo and sss_back.
`default_nettype none

//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_stall | mode, key (sss_pkg::in_beat_t)
//  rsp     | out       | rsp_valid / rsp_stall | status, value, count (out_beat_t)
//
//  Each command goes through a load step, which compares every cell against
//  the key, then an update step, which shifts the row and registers the
//  response; the back end pops the next command only after that update step.
//  An accepted beat goes to a queue slot, then the load registers, then rsp_reg.
//  Reset clears the count, the queue and the response register; key cells
//  are not cleared, since only cells below the count are ever read.
//  A stalled response holds the back end in its update step; the 2-entry
//  queue then fills and req_stall rises.

module sorted_set_store_unit #(
    parameter int CAPACITY = sss_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sss_pkg::KEY_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire sss_pkg::in_beat_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output sss_pkg::out_beat_t      rsp
);
    import sss_pkg::*;

    // front end to queue
    logic  q_full;
    logic  push;
    cmd_t  push_cmd;

    // queue to back end
    logic  q_valid;
    logic  q_pop;
    cmd_t  q_head;

    // decode mode into an operation class plus a take flag
    sss_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decouples acceptance from execution
    sss_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_head)
    );

    // sorted cell row: compare step, then shift and respond
    sss_back #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- dv/sss_set_checker.sv -----
// Checker for the sorted set store: keeps its own ordered key set, predicts each response
// from the accepted request beats and compares it with the response beats.
// Depends on sss_pkg for the beat types, mode codes and status codes.

module sss_set_checker #(
    parameter int CAPACITY = sss_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  sss_pkg::in_beat_t  req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  sss_pkg::out_beat_t rsp,
    output int                 fails,
    output int                 pending,
    output int                 checked,
    output int                 full_seen
);
    import sss_pkg::*;

    logic [31:0] set_keys [CAPACITY];
    int          held;
    out_beat_t   due_rsp_q [$];
    int          n_fail;
    int          n_checked;
    int          n_full;

    // number of held keys strictly below k
    function automatic int rank_of(logic [31:0] k);
        int n;
        n = 0;
        for (int i = 0; i < held; i++)
            if (set_keys[i] < k)
                n++;
        return n;
    endfunction

    function automatic void drop_slot(int p);
        for (int i = p; i + 1 < held; i++)
            set_keys[i] = set_keys[i + 1];
        held--;
    endfunction

    function automatic out_beat_t apply_set_op(in_beat_t b);
        out_beat_t r;
        int        p;
        r.status = ST_OK;
        r.value  = '0;
        case (b.mode)
            MODE_INSERT: begin
                p = rank_of(b.key);
                if (p < held && set_keys[p] == b.key)
                    r.status = ST_DUP;
                else if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = held; i > p; i--)
                        set_keys[i] = set_keys[i - 1];
                    set_keys[p] = b.key;
                    held++;
                end
            end
            MODE_REMOVE, MODE_EXISTS: begin
                p = rank_of(b.key);
                if (!(p < held && set_keys[p] == b.key))
                    r.status = ST_ABSENT;
                else if (b.mode == MODE_REMOVE)
                    drop_slot(p);
            end
            MODE_MIN, MODE_MAX, MODE_TAKE_MIN, MODE_TAKE_MAX: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    p = (b.mode == MODE_MIN || b.mode == MODE_TAKE_MIN) ? 0 : held - 1;
                    r.value = set_keys[p];
                    if (b.mode == MODE_TAKE_MIN || b.mode == MODE_TAKE_MAX)
                        drop_slot(p);
                end
            end
            MODE_PRED, MODE_TAKE_PRED: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    p = rank_of(b.key);
                    if (p == 0)
                        r.status = ST_ABSENT;
                    else
                    begin
                        r.value = set_keys[p - 1];
                        if (b.mode == MODE_TAKE_PRED)
                            drop_slot(p - 1);
                    end
                end
            end
            MODE_SUCC, MODE_TAKE_SUCC: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    p = rank_of(b.key);
                    if (p < held && set_keys[p] == b.key)
                        p++;
                    if (p >= held)
                        r.status = ST_ABSENT;
                    else
                    begin
                        r.value = set_keys[p];
                        if (b.mode == MODE_TAKE_SUCC)
                            drop_slot(p);
                    end
                end
            end
            MODE_CLEAR: held = 0;
            default: ;
        endcase
        r.count = 7'(held);
        return r;
    endfunction

    function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: rsp %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t want;
        if (!rst_n)
        begin
            held = 0;
            due_rsp_q.delete();
            n_fail = 0;
            n_checked = 0;
            n_full = 0;
        end
        else
        begin
            // a response can never belong to a request taken on the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    $display("%0t: rsp beat with none due, expected nothing, actual %0d/0x%0h/%0d",
                             $time, rsp.status, rsp.value, rsp.count);
                    n_fail++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    report_field("status", 32'(want.status), 32'(rsp.status));
                    report_field("value", want.value, rsp.value);
                    report_field("count", 32'(want.count), 32'(rsp.count));
                    n_checked++;
                    if (rsp.status == ST_FULL)
                        n_full++;
                end
            end
            if (req_valid && !req_stall)
                due_rsp_q.push_back(apply_set_op(req));
        end
        fails     <= n_fail;
        pending   <= due_rsp_q.size();
        checked   <= n_checked;
        full_seen <= n_full;
    end

endmodule

// ----- dv/tb_sorted_set_store_unit.sv -----
// Testbench top for sorted_set_store_unit: drives request beats and response stalls,
// runs a directed pass then random phases, and gives the verdict.
// Depends on sss_pkg, sorted_set_store_unit and sss_set_checker.

module tb_sorted_set_store_unit;
    import sss_pkg::*;

    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_BEATS   = 1900;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int IDLE_PCT       = 13;

    // phase flavors of the random part
    typedef enum int { PH_FILL, PH_MIX, PH_DRAIN } phase_kind_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       rsp_stall = 1'b0;
    in_beat_t   req       = '0;
    logic       req_stall;
    logic       rsp_valid;
    out_beat_t  rsp;

    logic       quiet       = 1'b0;  // no idling on either side while set
    int         squeeze_tag = 0;     // bumped by the sender to start a long rsp hold-off
    int         squeeze_seen = 0;
    int         hold_left   = 0;
    int         cycles      = 0;
    int         beats_sent  = 0;

    int         fails;
    int         pending;
    int         checked;
    int         full_seen;

    sorted_set_store_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sss_set_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .fails     (fails),
        .pending   (pending),
        .checked   (checked),
        .full_seen (full_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: any hang or lost response ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Response side. A new squeeze tag starts a long hold-off counted here, while the
    // sender keeps offering beats: the queue fills and req_stall must rise. Otherwise
    // stall at random unless the quiet stretch is on.
    always @(posedge clk)
    begin
        if (squeeze_tag != squeeze_seen)
        begin
            squeeze_seen <= squeeze_tag;
            hold_left    <= SQUEEZE_CYCLES;
            rsp_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Offer one beat and hold it until taken. valid stays high into the next beat
    // unless we decide to idle, so it never gets two updates in one step.
    task automatic offer_beat(input logic [3:0] m, input logic [31:0] k);
        req_valid <= 1'b1;
        req       <= '{mode: m, key: k};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_sent++;
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Keys mostly come from a narrow window so hits, duplicates and neighbors happen;
    // some are fully random or pinned to the ends of the key range.
    function automatic logic [31:0] pick_key(logic [31:0] base, int span);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return base + 32'($urandom_range(span - 1));
        endcase
    endfunction

    function automatic logic [3:0] pick_mode(phase_kind_t kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            PH_FILL:
                if (r < 85)
                    return MODE_INSERT;
            PH_DRAIN:
                if (r < 35)
                    return MODE_REMOVE;
                else if (r < 60)
                    case ($urandom_range(3))
                        0:       return MODE_TAKE_MIN;
                        1:       return MODE_TAKE_MAX;
                        2:       return MODE_TAKE_PRED;
                        default: return MODE_TAKE_SUCC;
                    endcase
            default: ;
        endcase
        // background mix: clear and the unused codes stay rare
        r = $urandom_range(99);
        if (r < 2)
            return MODE_CLEAR;
        else if (r < 6)
            return 4'($urandom_range(MODE_CLEAR + 1, 4'hF));
        return 4'($urandom_range(MODE_INSERT, MODE_TAKE_SUCC));
    endfunction

    initial
    begin : stimulus
        phase_kind_t kind;
        logic [31:0] base;
        int          span;
        int          phase_len;
        int          phase_no;
        int          random_sent;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every lookup on an empty set, misses, ends of the key range
        offer_beat(MODE_MIN, 32'h0);
        offer_beat(MODE_MAX, 32'h0);
        offer_beat(MODE_TAKE_MIN, 32'h0);
        offer_beat(MODE_TAKE_MAX, 32'h0);
        offer_beat(MODE_PRED, 32'hFFFF_FFFF);
        offer_beat(MODE_SUCC, 32'h0);
        offer_beat(MODE_TAKE_PRED, 32'h5);
        offer_beat(MODE_TAKE_SUCC, 32'h5);
        offer_beat(MODE_REMOVE, 32'h7);
        offer_beat(MODE_EXISTS, 32'h7);
        offer_beat(MODE_INSERT, 32'h0);
        offer_beat(MODE_INSERT, 32'hFFFF_FFFF);
        offer_beat(MODE_INSERT, 32'h0);          // duplicate
        offer_beat(MODE_INSERT, 32'd100);
        offer_beat(MODE_EXISTS, 32'd100);
        offer_beat(MODE_PRED, 32'h0);            // nothing below the smallest
        offer_beat(MODE_SUCC, 32'hFFFF_FFFF);    // nothing above the largest
        offer_beat(MODE_PRED, 32'hFFFF_FFFF);
        offer_beat(MODE_SUCC, 32'h0);            // present key is skipped
        offer_beat(MODE_TAKE_PRED, 32'd100);
        offer_beat(MODE_TAKE_SUCC, 32'd100);
        offer_beat(MODE_MIN, 32'h0);
        offer_beat(MODE_TAKE_MAX, 32'h0);
        offer_beat(4'hF, 32'hA5A5_5A5A);         // unused code, no change
        offer_beat(MODE_CLEAR, 32'h0);

        // random: rotating fill / mix / drain phases with a varying key window
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_BEATS)
        begin
            case (phase_no % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIX;
            endcase
            case ($urandom_range(3))
                0:       span = 40;
                1:       span = 90;
                2:       span = 300;
                default: span = 1000;
            endcase
            case ($urandom_range(2))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_FFFF - 32'(span - 1);
                default: base = $urandom & 32'hFFFF_F000;
            endcase
            phase_len = (kind == PH_FILL) ? 120 : $urandom_range(60, 160);
            if (phase_len > RANDOM_BEATS - random_sent)
                phase_len = RANDOM_BEATS - random_sent;

            quiet <= (phase_no % 5 == 3);
            // long response hold-off twice, both during fill phases
            if (phase_no == 4 || phase_no == 12)
                squeeze_tag <= squeeze_tag + 1;

            repeat (phase_len)
            begin
                offer_beat(pick_mode(kind), pick_key(base, span));
                random_sent++;
            end
            phase_no++;
        end

        // drain: let the checker log the last beat, wait out every due response,
        // then watch for stray responses
        req_valid <= 1'b0;
        quiet     <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d request beats over %0d random phases, %0d responses checked",
                 beats_sent, phase_no, checked);
        $display("store-full rejects seen: %0d, long response hold-offs: %0d",
                 full_seen, squeeze_tag);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sorted_set_store_unit.f -----
rtl/sss_pkg.sv
rtl/sss_front.sv
rtl/sss_fifo.sv
rtl/sss_back.sv
rtl/sorted_set_store_unit.sv
dv/sss_set_checker.sv
dv/tb_sorted_set_store_unit.sv
